>>> hw/rtl/csem_pkg.sv
// Shared types and constants for the counting semaphore wait queue core.
// Holds the request/response payloads, status and request codes, and the
// wait-store control bundle. No dependencies.
package csem_pkg;

  localparam int ReqBits    = 2;
  localparam int SemIdBits  = 4;
  localparam int PidBits    = 5;
  localparam int InitBits   = 8;
  localparam int StatusBits = 3;
  localparam int IdxMaxBits = 8;

  localparam int DefNumSems    = 16;
  localparam int DefQueueDepth = 16;
  localparam int DefNumPids    = 32;
  localparam int DefCountBits  = 8;

  localparam logic [ReqBits-1:0] ReqCreate  = 2'd0;
  localparam logic [ReqBits-1:0] ReqLock    = 2'd1;
  localparam logic [ReqBits-1:0] ReqUnlock  = 2'd2;
  localparam logic [ReqBits-1:0] ReqInvalid = 2'd3;

  localparam logic [StatusBits-1:0] StDone      = 3'd0;
  localparam logic [StatusBits-1:0] StSuspended = 3'd1;
  localparam logic [StatusBits-1:0] StInvalid   = 3'd2;
  localparam logic [StatusBits-1:0] StQueueFull = 3'd3;
  localparam logic [StatusBits-1:0] StNoSem     = 3'd4;

  typedef struct packed {
    logic [ReqBits-1:0]   req_type;
    logic [SemIdBits-1:0] sem_id;
    logic [PidBits-1:0]   caller_pid;
    logic [InitBits-1:0]  init_count;
  } req_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [SemIdBits-1:0]  created_id;
    logic                  woken_valid;
    logic [PidBits-1:0]    woken_pid;
  } rsp_t;

  typedef struct packed {
    logic                  wr_en;
    logic [IdxMaxBits-1:0] wr_sem;
    logic [IdxMaxBits-1:0] wr_slot;
    logic [PidBits-1:0]    wr_pid;
    logic                  rd_en;
    logic [IdxMaxBits-1:0] rd_sem;
    logic [IdxMaxBits-1:0] rd_slot;
  } wq_ctrl_t;

endpackage

>>> hw/rtl/csem_stream_if.sv
// Valid/ready stream interface used for the request and response channels.
// Payload type is a parameter; no package dependency.
interface csem_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/csem_waitq.sv
// Waiter store: one pid ring per semaphore, one write and one read per cycle.
// Read data is registered. Depends on csem_pkg.
module csem_waitq import csem_pkg::*; #(
  parameter int NUM_SEMS    = DefNumSems,
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int STORE_W     = PidBits
) (
  input  logic               clk,
  input  wq_ctrl_t           ctrl,
  output logic [STORE_W-1:0] rd_data
);

  localparam int SEM_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int Q_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [STORE_W-1:0] mem [NUM_SEMS][QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_sem[SEM_W-1:0]][ctrl.wr_slot[Q_W-1:0]] <= ctrl.wr_pid[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_sem[SEM_W-1:0]][ctrl.rd_slot[Q_W-1:0]];
    end
  end

endmodule

>>> hw/rtl/counting_semaphore_wait_queue_core.sv
// Counting semaphore unit with a FIFO wait queue per semaphore.
// Depends on csem_pkg, csem_stream_if and csem_waitq.
//
// Usage:
//   req (sink): one request per transfer: create, lock, unlock or invalid.
//   rsp (source): exactly one response per request, in request order.
// Flow: a request is worked when the response register loads; the response
//   is valid from then until taken. Throughput: one request per cycle unless
//   stalled. Per-semaphore count, ring pointers and fill live in flip-flops
//   and are updated at the same edge that loads the response, so the next
//   request sees them at once; the waiter store takes one write (lock that
//   suspends) or one read (unlock that wakes) per cycle.
// Reset (rst, synchronous): counts, pointers, fills and the next free id go
//   to zero and both pipeline stages empty. The waiter store is not cleared;
//   only entries written by a lock are ever read.
// Stall: while rsp.ready is low the response holds, the input stage holds
//   one more request, and req.ready drops once that stage is full.
module counting_semaphore_wait_queue_core import csem_pkg::*; #(
  parameter int NUM_SEMS    = DefNumSems,
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int NUM_PIDS    = DefNumPids,
  parameter int COUNT_BITS  = DefCountBits
) (
  input  logic          clk,
  input  logic          rst,
  csem_stream_if.sink   req,
  csem_stream_if.source rsp
);

  localparam int SEM_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int Q_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NF_W    = $clog2(NUM_SEMS + 1);
  localparam int PID_W   = $clog2(NUM_PIDS);
  localparam int STORE_W = (PID_W < PidBits) ? PID_W : PidBits;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  s1_valid;
  req_t                  s1;
  logic                  out_valid;
  logic [StatusBits-1:0] out_status;
  logic [SemIdBits-1:0]  out_created;
  logic                  out_woken;
  logic [STORE_W-1:0]    rd_data;

  logic [COUNT_BITS-1:0] sem_count  [NUM_SEMS];
  logic [Q_W-1:0]        queue_head [NUM_SEMS];
  logic [Q_W-1:0]        queue_tail [NUM_SEMS];
  logic [FILL_W-1:0]     queue_fill [NUM_SEMS];
  logic [NF_W-1:0]       next_free_sem;

  logic                  adv;
  logic                  fire;
  logic [31:0]           sid_ext;
  logic [31:0]           nf_ext;
  logic [31:0]           init_ext;
  logic [SEM_W-1:0]      sid;
  logic                  sid_ok;
  logic [COUNT_BITS-1:0] cnt;
  logic [Q_W-1:0]        hd;
  logic [Q_W-1:0]        tl;
  logic [FILL_W-1:0]     fl;

  logic [StatusBits-1:0] status;
  logic [SemIdBits-1:0]  created;
  logic                  woken;
  logic                  wr_entry;
  logic [SEM_W-1:0]      ent;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [Q_W-1:0]        hd_next;
  logic [Q_W-1:0]        tl_next;
  logic [FILL_W-1:0]     fl_next;
  logic                  nf_bump;
  logic                  q_push;
  logic                  q_pop;
  wq_ctrl_t              wq_ctrl;

  function automatic logic [Q_W-1:0] ring_next(input logic [Q_W-1:0] p);
    logic [31:0] pn;
    pn = 32'(p) + 32'd1;
    return (pn >= QUEUE_DEPTH) ? '0 : pn[Q_W-1:0];
  endfunction

  assign adv       = !out_valid || rsp.ready;
  assign fire      = s1_valid && adv;
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.data;
    end
  end

  assign sid_ext  = 32'(s1.sem_id);
  assign nf_ext   = 32'(next_free_sem);
  assign init_ext = 32'(s1.init_count);
  assign sid      = sid_ext[SEM_W-1:0];
  assign sid_ok   = sid_ext < NUM_SEMS;
  assign cnt      = sem_count[sid];
  assign hd       = queue_head[sid];
  assign tl       = queue_tail[sid];
  assign fl       = queue_fill[sid];

  always_comb begin
    status   = StDone;
    created  = '0;
    woken    = 1'b0;
    wr_entry = 1'b0;
    ent      = sid;
    cnt_next = cnt;
    hd_next  = hd;
    tl_next  = tl;
    fl_next  = fl;
    nf_bump  = 1'b0;
    q_push   = 1'b0;
    q_pop    = 1'b0;
    priority if (s1.req_type == ReqCreate) begin
      if (nf_ext >= NUM_SEMS) begin
        status = StNoSem;
      end else begin
        ent      = nf_ext[SEM_W-1:0];
        created  = nf_ext[SemIdBits-1:0];
        cnt_next = (init_ext > 32'(COUNT_MAX)) ? COUNT_MAX : init_ext[COUNT_BITS-1:0];
        hd_next  = '0;
        tl_next  = '0;
        fl_next  = '0;
        wr_entry = 1'b1;
        nf_bump  = 1'b1;
      end
    end else if (s1.req_type == ReqInvalid || !sid_ok) begin
      status = StInvalid;
    end else if (s1.req_type == ReqLock) begin
      priority if (cnt != '0) begin
        cnt_next = cnt - 1'b1;
        wr_entry = 1'b1;
      end else if (32'(s1.caller_pid) >= NUM_PIDS) begin
        status = StInvalid;
      end else if (32'(fl) >= QUEUE_DEPTH) begin
        status = StQueueFull;
      end else begin
        tl_next  = ring_next(tl);
        fl_next  = fl + 1'b1;
        q_push   = 1'b1;
        wr_entry = 1'b1;
        status   = StSuspended;
      end
    end else begin
      priority if (fl != '0) begin
        hd_next  = ring_next(hd);
        fl_next  = fl - 1'b1;
        q_pop    = 1'b1;
        woken    = 1'b1;
        wr_entry = 1'b1;
      end else if (cnt != COUNT_MAX) begin
        cnt_next = cnt + 1'b1;
        wr_entry = 1'b1;
      end else begin
        wr_entry = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_count[i]  <= '0;
        queue_head[i] <= '0;
        queue_tail[i] <= '0;
        queue_fill[i] <= '0;
      end
      next_free_sem <= '0;
    end else if (fire) begin
      if (wr_entry) begin
        sem_count[ent]  <= cnt_next;
        queue_head[ent] <= hd_next;
        queue_tail[ent] <= tl_next;
        queue_fill[ent] <= fl_next;
      end
      if (nf_bump) begin
        next_free_sem <= NF_W'(nf_ext + 32'd1);
      end
    end
  end

  always_comb begin
    wq_ctrl.wr_en   = fire && q_push;
    wq_ctrl.wr_sem  = IdxMaxBits'(sid);
    wq_ctrl.wr_slot = IdxMaxBits'(tl);
    wq_ctrl.wr_pid  = s1.caller_pid;
    wq_ctrl.rd_en   = fire && q_pop;
    wq_ctrl.rd_sem  = IdxMaxBits'(sid);
    wq_ctrl.rd_slot = IdxMaxBits'(hd);
  end

  csem_waitq #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STORE_W     (STORE_W)
  ) u_waitq (
    .clk     (clk),
    .ctrl    (wq_ctrl),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status  <= status;
      out_created <= created;
      out_woken   <= woken;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.data.status      = out_status;
  assign rsp.data.created_id  = out_created;
  assign rsp.data.woken_valid = out_woken;
  assign rsp.data.woken_pid   = out_woken ? PidBits'(rd_data) : '0;

  a_woken_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.woken_valid |-> rsp.data.status == StDone)
    else $error("woken response without done status");

  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.valid)
    else $error("worked request produced no response");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_free_sem) <= NUM_SEMS)
    else $error("next free id past semaphore count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fire && wr_entry |=> 32'(queue_fill[$past(ent)]) <= QUEUE_DEPTH)
    else $error("wait queue fill past depth");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(wq_ctrl.wr_en && wq_ctrl.rd_en))
    else $error("wait store written and read in one cycle");

endmodule
